// ----- src/ucd_pkg.sv -----
// ----------------------------------------------------------------------------
// ucd_pkg
// Shared command codes for the undirected cycle detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucd_pkg;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_CHECK = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/undirected_cycle_detect_dfs.sv -----
// ----------------------------------------------------------------------------
// undirected_cycle_detect_dfs
// Adjacency bit matrix with add-edge, clear and a depth-first cycle check.
//
//   channel | direction | fields                                   | transfer
//   req     | in        | command, node_a, node_b, both_ways        | valid & ready
//   rsp     | out       | has_cycle (check only)                    | valid & ready
//
// Add edge sets a bit in node_a's row, then in node_b's row with both_ways.
// Clear zeroes the matrix one row at a time. Check scans one adjacency bit
// per cycle from the row held in the adjacency memory read register.
// Reset starts a clearing pass over the matrix; req_ready is low meanwhile.
// A finished check result waits in the rsp register; the block takes new
// commands meanwhile and stalls only if a second check result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module undirected_cycle_detect_dfs #(
   parameter int NODES = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [1:0] req_command,
   input  wire logic [5:0] req_node_a,
   input  wire logic [5:0] req_node_b,
   input  wire logic       req_both_ways,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_has_cycle
);

   localparam int IW = $clog2(NODES);
   localparam int CW = $clog2(NODES + 1);

   typedef struct packed {
      logic [IW-1:0] node;
      logic [IW-1:0] parent;
      logic          parent_valid;
      logic [IW-1:0] last;
   } frame_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_A,
      S_ADD_B_RD,
      S_ADD_B,
      S_ROOT,
      S_SCAN,
      S_POP,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    cnt_ff, cnt_in;
   logic [IW-1:0]    edge_a_ff, edge_a_in;
   logic [IW-1:0]    edge_b_ff, edge_b_in;
   logic             both_ff, both_in;
   logic [CW-1:0]    root_ff, root_in;
   logic [CW-1:0]    scan_ff, scan_in;
   logic [CW-1:0]    depth_ff, depth_in;
   frame_type        top_ff, top_in;
   logic [NODES-1:0] visited_ff, visited_in;
   logic             found_ff, found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_has_cycle_ff, rsp_has_cycle_in;

   logic [NODES-1:0] adj_mem [NODES];
   logic [NODES-1:0] adj_rd_ff;
   logic             adj_we, adj_re;
   logic [IW-1:0]    adj_waddr, adj_raddr;
   logic [NODES-1:0] adj_wdata;

   frame_type        stk_mem [NODES];
   frame_type        stk_rd_ff;
   logic             stk_we, stk_re;
   logic [IW-1:0]    stk_waddr, stk_raddr;
   frame_type        stk_wdata;

   logic             accept;
   logic             in_range;
   logic [IW-1:0]    scan_idx;
   logic [CW-1:0]    depth_m1, depth_m2;

   assign accept    = req_valid && req_ready;
   assign in_range  = (32'(req_node_a) < NODES) && (32'(req_node_b) < NODES);
   assign scan_idx  = scan_ff[IW-1:0];
   assign depth_m1  = depth_ff - CW'(1);
   assign depth_m2  = depth_ff - CW'(2);

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_has_cycle = rsp_has_cycle_ff;

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      edge_a_in        = edge_a_ff;
      edge_b_in        = edge_b_ff;
      both_in          = both_ff;
      root_in          = root_ff;
      scan_in          = scan_ff;
      depth_in         = depth_ff;
      top_in           = top_ff;
      visited_in       = visited_ff;
      found_in         = found_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_has_cycle_in = rsp_has_cycle_ff;
      adj_we           = 1'b0;
      adj_waddr        = cnt_ff;
      adj_wdata        = '0;
      adj_re           = 1'b0;
      adj_raddr        = edge_a_ff;
      stk_we           = 1'b0;
      stk_waddr        = depth_m1[IW-1:0];
      stk_wdata        = top_ff;
      stk_re           = 1'b0;
      stk_raddr        = depth_m2[IW-1:0];

      case (state_ff)
         S_CLEAR: begin
            adj_we    = 1'b1;
            adj_waddr = cnt_ff;
            cnt_in    = cnt_ff + IW'(1);
            if (cnt_ff == IW'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  ucd_pkg::CMD_ADD: begin
                     edge_a_in = IW'(req_node_a);
                     edge_b_in = IW'(req_node_b);
                     both_in   = req_both_ways;
                     if (in_range) begin
                        adj_re    = 1'b1;
                        adj_raddr = IW'(req_node_a);
                        state_in  = S_ADD_A;
                     end
                  end
                  ucd_pkg::CMD_CHECK: begin
                     visited_in = '0;
                     root_in    = '0;
                     depth_in   = '0;
                     state_in   = S_ROOT;
                  end
                  ucd_pkg::CMD_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_A: begin
            adj_we    = 1'b1;
            adj_waddr = edge_a_ff;
            adj_wdata = adj_rd_ff | (NODES'(1) << edge_b_ff);
            state_in  = both_ff ? S_ADD_B_RD : S_IDLE;
         end
         S_ADD_B_RD: begin
            adj_re    = 1'b1;
            adj_raddr = edge_b_ff;
            state_in  = S_ADD_B;
         end
         S_ADD_B: begin
            adj_we    = 1'b1;
            adj_waddr = edge_b_ff;
            adj_wdata = adj_rd_ff | (NODES'(1) << edge_a_ff);
            state_in  = S_IDLE;
         end
         S_ROOT: begin
            if (root_ff == CW'(NODES)) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else if (visited_ff[root_ff[IW-1:0]]) begin
               root_in = root_ff + CW'(1);
            end else begin
               visited_in[root_ff[IW-1:0]] = 1'b1;
               top_in.node         = root_ff[IW-1:0];
               top_in.parent       = '0;
               top_in.parent_valid = 1'b0;
               top_in.last         = '0;
               scan_in             = '0;
               depth_in            = CW'(1);
               adj_re              = 1'b1;
               adj_raddr           = root_ff[IW-1:0];
               state_in            = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff == CW'(NODES)) begin
               depth_in = depth_m1;
               if (depth_ff == CW'(1)) begin
                  root_in  = root_ff + CW'(1);
                  state_in = S_ROOT;
               end else begin
                  stk_re   = 1'b1;
                  state_in = S_POP;
               end
            end else if (!adj_rd_ff[scan_idx]) begin
               scan_in = scan_ff + CW'(1);
            end else if (!visited_ff[scan_idx]) begin
               visited_in[scan_idx] = 1'b1;
               if (depth_ff < CW'(NODES)) begin
                  stk_we              = 1'b1;
                  stk_wdata.last      = scan_idx;
                  top_in.node         = scan_idx;
                  top_in.parent       = top_ff.node;
                  top_in.parent_valid = 1'b1;
                  top_in.last         = '0;
                  scan_in             = '0;
                  depth_in            = depth_ff + CW'(1);
                  adj_re              = 1'b1;
                  adj_raddr           = scan_idx;
               end else begin
                  scan_in = scan_ff + CW'(1);
               end
            end else if (!top_ff.parent_valid || scan_idx != top_ff.parent) begin
               found_in = 1'b1;
               depth_in = '0;
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         S_POP: begin
            top_in    = stk_rd_ff;
            scan_in   = {1'b0, stk_rd_ff.last} + CW'(1);
            adj_re    = 1'b1;
            adj_raddr = stk_rd_ff.node;
            state_in  = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_has_cycle_in = found_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         depth_ff     <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      edge_a_ff        <= edge_a_in;
      edge_b_ff        <= edge_b_in;
      both_ff          <= both_in;
      root_ff          <= root_in;
      scan_ff          <= scan_in;
      top_ff           <= top_in;
      found_ff         <= found_in;
      rsp_has_cycle_ff <= rsp_has_cycle_in;
   end

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[adj_waddr] <= adj_wdata;
      end
      if (adj_re) begin
         adj_rd_ff <= adj_mem[adj_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

endmodule

`default_nettype wire

// ----- src/ucd_checker.sv -----
// ----------------------------------------------------------------------------
// ucd_checker
// Port-level checks for the undirected cycle detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_command,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_has_cycle
);

   logic       check_xfer;
   logic       rsp_xfer;
   logic [1:0] open_ff, open_in;

   assign check_xfer = req_valid && req_ready &&
                       (req_command == ucd_pkg::CMD_CHECK);
   assign rsp_xfer   = rsp_valid && rsp_ready;

   always_comb begin
      open_in = open_ff;
      if (check_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (!check_xfer && rsp_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // matrix clearing pass follows reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_has_cycle))
      else $error("stalled result changed");

   a_rsp_has_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result without a pending check");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two checks outstanding");

   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      check_xfer |=> !req_ready)
      else $error("request taken during a check walk");

endmodule

bind undirected_cycle_detect_dfs ucd_checker u_ucd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_command   (req_command),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_has_cycle (rsp_has_cycle)
);

`default_nettype wire

// ----- bench/undirected_cycle_detect_dfs_tb.sv -----
// ----------------------------------------------------------------------------
// undirected_cycle_detect_dfs_tb
// Drives add-edge, clear and check commands into the cycle detector. A local
// depth-first predictor works out each check verdict at the req transfer, and
// the monitor compares every rsp transfer against the oldest open verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module undirected_cycle_detect_dfs_tb;

   localparam int NODES = 64;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int TARGET_CMDS = 140;
   localparam int CALM_TAIL = 16;
   localparam int SETTLE_CYCLES = NODES * NODES + 4 * NODES + 16;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] node_a;
      logic [5:0] node_b;
      logic       both_ways;
   } graph_cmd_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = ucd_pkg::CMD_CLEAR;
   logic [5:0] req_node_a = '0;
   logic [5:0] req_node_b = '0;
   logic       req_both_ways = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_has_cycle;

   graph_cmd_type cmd_backlog[$];
   bit         cycle_verdicts[$];
   logic [NODES-1:0] edge_rows [NODES];
   graph_cmd_type next_cmd;
   bit         want_cycle;
   bit         calm_phase = 1'b0;
   int         req_hold = 0;
   int         rsp_hold = 0;
   int         faults = 0;
   int         cmds_issued = 0;
   int         cmds_taken = 0;
   int         checks_run = 0;
   int         cycles_found = 0;

   undirected_cycle_detect_dfs #(.NODES(NODES)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_node_a   (req_node_a),
      .req_node_b   (req_node_b),
      .req_both_ways(req_both_ways),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_has_cycle(rsp_has_cycle)
   );

   always #6 clock = ~clock;

   function automatic bit graph_has_cycle();
      logic [NODES-1:0] seen;
      logic [5:0] st_node [NODES];
      logic [5:0] st_par [NODES];
      bit         st_pv [NODES];
      int         st_next [NODES];
      int         depth;
      int         j;
      bit         hit;
      seen = '0;
      hit = 1'b0;
      for (int r = 0; r < NODES && !hit; r++) begin
         if (!seen[r]) begin
            seen[r] = 1'b1;
            st_node[0] = 6'(r);
            st_par[0] = '0;
            st_pv[0] = 1'b0;
            st_next[0] = 0;
            depth = 1;
            while (depth > 0 && !hit) begin
               j = st_next[depth-1];
               while (j < NODES && !edge_rows[st_node[depth-1]][j])
                  j++;
               if (j >= NODES) begin
                  depth--;
               end else begin
                  st_next[depth-1] = j + 1;
                  if (!seen[j]) begin
                     seen[j] = 1'b1;
                     if (depth < NODES) begin
                        st_node[depth] = 6'(j);
                        st_par[depth] = st_node[depth-1];
                        st_pv[depth] = 1'b1;
                        st_next[depth] = 0;
                        depth++;
                     end
                  end else if (!st_pv[depth-1] || j != st_par[depth-1]) begin
                     hit = 1'b1;
                  end
               end
            end
         end
      end
      return hit;
   endfunction

   task automatic apply_cmd(input logic [1:0] c, input logic [5:0] a,
                            input logic [5:0] b, input logic w);
      bit verdict;
      case (c)
         ucd_pkg::CMD_ADD: begin
            edge_rows[a][b] = 1'b1;
            if (w)
               edge_rows[b][a] = 1'b1;
         end
         ucd_pkg::CMD_CHECK: begin
            verdict = graph_has_cycle();
            cycle_verdicts = {cycle_verdicts, verdict};
            checks_run++;
            if (verdict)
               cycles_found++;
         end
         ucd_pkg::CMD_CLEAR: begin
            foreach (edge_rows[i])
               edge_rows[i] = '0;
         end
         default: ;
      endcase
   endtask

   task automatic push_cmd(input logic [1:0] c, input logic [5:0] a,
                           input logic [5:0] b, input logic w);
      graph_cmd_type item;
      item.command = c;
      item.node_a = a;
      item.node_b = b;
      item.both_ways = w;
      cmd_backlog = {cmd_backlog, item};
      if (c != CMD_UNUSED)
         cmds_issued++;
   endtask

   task automatic note_fault(input string msg);
      faults++;
      if (faults <= 10)
         $display("%0t ns: %s", $time, msg);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold <= 0;
      end else begin
         if (req_valid && req_ready) begin
            apply_cmd(req_command, req_node_a, req_node_b, req_both_ways);
            cmds_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_hold > 0) begin
               req_hold <= req_hold - 1;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
               req_hold <= $urandom_range(0, 15);
               req_valid <= 1'b0;
            end else begin
               next_cmd = cmd_backlog.pop_front();
               req_command <= next_cmd.command;
               req_node_a <= next_cmd.node_a;
               req_node_b <= next_cmd.node_b;
               req_both_ways <= next_cmd.both_ways;
               req_valid <= 1'b1;
            end
            calm_phase <= cmd_backlog.size() < CALM_TAIL;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cycle_verdicts.size() == 0) begin
               note_fault($sformatf("rsp transfer with no check open, has_cycle=%0b",
                                    rsp_has_cycle));
            end else begin
               want_cycle = cycle_verdicts.pop_front();
               if (rsp_has_cycle !== want_cycle)
                  note_fault($sformatf("has_cycle mismatch: expected %0b, got %0b",
                                       want_cycle, rsp_has_cycle));
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            rsp_hold <= $urandom_range(0, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #30000000;
      $display("timeout: %0d checks still open", cycle_verdicts.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [5:0] lab [8];
      int k;
      foreach (edge_rows[i])
         edge_rows[i] = '0;

      // empty graph, coalesced edge, self-loop off the root
      push_cmd(ucd_pkg::CMD_CLEAR, 6'd63, 6'd63, 1'b1);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd0, 6'd63, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd0, 6'd63, 1'b1);
      push_cmd(ucd_pkg::CMD_ADD, 6'd63, 6'd0, 1'b1);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd63, 6'd0, 1'b1);
      push_cmd(ucd_pkg::CMD_ADD, 6'd63, 6'd63, 1'b0);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd0, 6'd0, 1'b0);
      // triangle closed on a chain
      push_cmd(ucd_pkg::CMD_CLEAR, 6'd0, 6'd0, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd0, 6'd1, 1'b1);
      push_cmd(ucd_pkg::CMD_ADD, 6'd1, 6'd2, 1'b1);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd1, 6'd2, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd2, 6'd0, 1'b1);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd2, 6'd0, 1'b1);
      // one-way edges stay one-way
      push_cmd(ucd_pkg::CMD_CLEAR, 6'd21, 6'd42, 1'b1);
      push_cmd(ucd_pkg::CMD_ADD, 6'd5, 6'd6, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd6, 6'd5, 1'b0);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd5, 6'd6, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd7, 6'd5, 1'b0);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd7, 6'd5, 1'b0);
      // unused command code must leave the graph alone
      push_cmd(CMD_UNUSED, 6'd63, 6'd63, 1'b1);
      push_cmd(CMD_UNUSED, 6'd0, 6'd0, 1'b0);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd42, 6'd21, 1'b1);
      push_cmd(ucd_pkg::CMD_CLEAR, 6'd42, 6'd21, 1'b0);
      push_cmd(ucd_pkg::CMD_ADD, 6'd42, 6'd21, 1'b1);
      push_cmd(ucd_pkg::CMD_CHECK, 6'd21, 6'd42, 1'b0);

      while (cmds_issued < TARGET_CMDS) begin
         if ($urandom_range(0, 9) < 7) begin
            // random forest, sometimes closed into a cycle
            push_cmd(ucd_pkg::CMD_CLEAR, 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            k = $urandom_range(2, 8);
            for (int i = 0; i < k; i++)
               lab[i] = 6'($urandom_range(0, 63));
            for (int i = 1; i < k; i++) begin
               if ($urandom_range(0, 4) == 0)
                  push_cmd(ucd_pkg::CMD_ADD, lab[i], lab[$urandom_range(0, i-1)], 1'b0);
               else if ($urandom_range(0, 1) == 0)
                  push_cmd(ucd_pkg::CMD_ADD, lab[i], lab[$urandom_range(0, i-1)], 1'b1);
               else
                  push_cmd(ucd_pkg::CMD_ADD, lab[$urandom_range(0, i-1)], lab[i], 1'b1);
               if ($urandom_range(0, 9) == 0)
                  push_cmd(ucd_pkg::CMD_CHECK, 6'($urandom_range(0, 63)),
                           6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1) == 0)
               push_cmd(ucd_pkg::CMD_ADD, lab[$urandom_range(0, k-1)],
                        lab[$urandom_range(0, k-1)], 1'($urandom_range(0, 1)));
            push_cmd(ucd_pkg::CMD_CHECK, 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         end else begin
            push_cmd(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                     6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (cmd_backlog.size() > 0 || req_valid)
         @(posedge clock);
      while (cycle_verdicts.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d commands, %0d cycle checks (%0d found a cycle)",
               cmds_taken, checks_run, cycles_found);
      if (faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d check failures", faults);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/ucd_pkg.sv
src/undirected_cycle_detect_dfs.sv
src/ucd_checker.sv
bench/undirected_cycle_detect_dfs_tb.sv
